FILE: sv/olid_pkg.sv
// Shared types and codes for the ordered list block.
`timescale 1ns / 1ps
`default_nettype none

package olid_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_POS  = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;    // insert or append at the given slot
        logic cmp;    // latch per-cell match flags
        logic del;    // resolve delete and close the gap
        logic found;  // some held entry matched
    } olid_ctl_t;

endpackage

`default_nettype wire

FILE: sv/ordered_list_insert_delete.sv
// Top level of the ordered list: control, cell chain and result register.
`timescale 1ns / 1ps
`default_nettype none

// Packed list of up to CAPACITY signed 32-bit entries held in a chain of cells.
// Append, insert and read: every cell decides in parallel whether to load,
// shift up or hold. Delete: on accept each cell latches a match flag, then
// the S_DEL state ripples those flags down the chain to find the highest
// matching entry and shifts the cells above it down by one.
// Results sit in an output register; a new beat is taken while the result is
// unclaimed only if out_ready frees that register in the same cycle.
// Rejected actions (full, bad position, not found) leave the list untouched.

module ordered_list_insert_delete
    import olid_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         action,
    input  wire logic signed [31:0] value,
    input  wire logic [3:0]         position,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic [4:0]              entry_count,
    output logic signed [31:0]      read_value,
    output logic [3:0]              removed_index
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int PW   = (CW > 4) ? CW : 4;
    localparam int EW   = (CW > 5) ? CW : 5;
    localparam int RW   = (IW > 4) ? IW : 4;
    localparam int RD_N = (CAPACITY < 16) ? CAPACITY : 16;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DEL  = 2'b10
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           out_valid_reg, out_valid_next;
    logic [1:0]     status_reg, status_next;
    logic [4:0]     entry_count_reg, entry_count_next;
    logic [31:0]    read_value_reg, read_value_next;
    logic [3:0]     removed_index_reg, removed_index_next;

    olid_ctl_t      ctl;
    logic           accept;
    logic           is_add;
    logic           full;
    logic           bad_add;
    logic           bad_read;
    logic [PW-1:0]  pos_ext;
    logic [PW-1:0]  count_pw;
    logic [PW-1:0]  at_pw;
    logic [CW-1:0]  at;
    logic [31:0]    cell_entry [CAPACITY];
    logic [CAPACITY:0]   above;
    logic [CAPACITY-1:0] kill;
    logic [31:0]    rd_mux;
    logic [IW-1:0]  hit_idx;
    logic [EW-1:0]  count_ew;
    logic [RW-1:0]  hit_rw;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign pos_ext  = PW'(position);
    assign count_pw = PW'(count_reg);
    assign is_add   = (action == ACT_APPEND) || (action == ACT_INSERT);
    assign full     = (count_reg == CW'(CAPACITY));
    assign at_pw    = (action == ACT_APPEND) ? count_pw : pos_ext;
    assign bad_add  = (at_pw > count_pw);
    assign bad_read = (pos_ext >= count_pw);
    assign at       = at_pw[CW-1:0];

    assign ctl.ins   = accept && is_add && !full && !bad_add;
    assign ctl.cmp   = accept && (action == ACT_DELETE);
    assign ctl.del   = (state_reg == S_DEL);
    assign ctl.found = above[0];

    assign above[CAPACITY] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [31:0] prev_e;
        logic [31:0] next_e;

        if (i == 0)
        begin : g_first
            assign prev_e = value;
        end
        else
        begin : g_prev
            assign prev_e = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_e = cell_entry[i];
        end
        else
        begin : g_next
            assign next_e = cell_entry[i+1];
        end

        olid_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .at         (at),
            .count      (count_reg),
            .value      (value),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .above_in   (above[i+1]),
            .above_out  (above[i]),
            .kill       (kill[i]),
            .entry      (cell_entry[i])
        );
    end

    // read port covers only the cells a 4-bit index can reach
    always_comb
    begin
        rd_mux = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (position == 4'(i))
                rd_mux = cell_entry[i];
        end
    end

    // kill is one-hot at the highest matching cell
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (kill[i])
                hit_idx = hit_idx | IW'(i);
        end
    end

    assign hit_rw   = RW'(hit_idx);
    assign count_ew = EW'(count_next);

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        status_next        = status_reg;
        read_value_next    = read_value_reg;
        removed_index_next = removed_index_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    read_value_next    = '0;
                    removed_index_next = '0;
                    status_next        = ST_OK;
                    if (action == ACT_DELETE)
                    begin
                        state_next = S_DEL;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        if (is_add)
                        begin
                            priority if (full)
                                status_next = ST_FULL;
                            else if (bad_add)
                                status_next = ST_BAD_POS;
                            else
                                count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            if (bad_read)
                                status_next = ST_BAD_POS;
                            else
                                read_value_next = rd_mux;
                        end
                    end
                end
            end
            S_DEL:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                if (ctl.found)
                begin
                    count_next         = count_reg - 1'b1;
                    removed_index_next = hit_rw[3:0];
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign entry_count_next = count_ew[4:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg        <= status_next;
        entry_count_reg   <= entry_count_next;
        read_value_reg    <= read_value_next;
        removed_index_reg <= removed_index_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign entry_count   = entry_count_reg;
    assign read_value    = read_value_reg;
    assign removed_index = removed_index_reg;

endmodule

`default_nettype wire

FILE: sv/olid_cell.sv
// One storage cell of the insertion list chain.
`timescale 1ns / 1ps
`default_nettype none

module olid_cell
    import olid_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire olid_ctl_t     ctl,
    input  wire logic [CW-1:0] at,
    input  wire logic [CW-1:0] count,
    input  wire logic [31:0]   value,
    input  wire logic [31:0]   prev_entry,
    input  wire logic [31:0]   next_entry,
    input  wire logic          above_in,
    output logic               above_out,
    output logic               kill,
    output logic [31:0]        entry
);

    localparam logic [CW-1:0] MY = CW'(IDX);

    logic [31:0] entry_reg;
    logic [31:0] entry_next;
    logic        match_reg;
    logic        match_next;
    logic        load;
    logic        shift_up;
    logic        shift_down;

    assign load       = ctl.ins && (MY == at);
    assign shift_up   = ctl.ins && (MY > at) && (MY <= count);
    // hit index <= this cell when nothing above matched
    assign shift_down = ctl.del && ctl.found && !above_in;

    always_comb
    begin
        priority if (load)
            entry_next = value;
        else if (shift_up)
            entry_next = prev_entry;
        else if (shift_down)
            entry_next = next_entry;
        else
            entry_next = entry_reg;
    end

    assign match_next = ctl.cmp ? ((MY < count) && (entry_reg == value)) : match_reg;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    assign above_out = above_in | match_reg;
    assign kill      = match_reg & ~above_in;
    assign entry     = entry_reg;

endmodule

`default_nettype wire

FILE: sv/olid_checker.sv
// Port-level checks for the ordered list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module olid_checker
    import olid_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [1:0]  action,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  status,
    input  wire logic [4:0]  entry_count,
    input  wire logic [31:0] read_value,
    input  wire logic [3:0]  removed_index
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(entry_count) && $stable(read_value) && $stable(removed_index))
        else $error("result beat changed while stalled");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result register is blocked");

    a_lat_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action != ACT_DELETE |=> out_valid)
        else $error("single-cycle action gave no result");

    a_lat_del: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ACT_DELETE |=> !out_valid ##1 out_valid)
        else $error("delete result not two cycles after accept");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> read_value == 32'd0 && removed_index == 4'd0
            && (status != ST_FULL || entry_count == 5'(CAPACITY)))
        else $error("rejected action carries data");

endmodule

bind ordered_list_insert_delete olid_checker #(.CAPACITY(CAPACITY)) u_olid_checker (.*);

`default_nettype wire
